### sv/brc_pkg.sv
// brc_pkg: shared widths, codes and item types of the box region classifier
`timescale 1ns / 1ps
`default_nettype none

package brc_pkg;

    localparam int COORD_BITS  = 12;
    localparam int CFG_BITS    = 13;
    localparam int QW          = (COORD_BITS > CFG_BITS) ? COORD_BITS + 2 : CFG_BITS + 2;
    localparam int LW          = QW + 1;
    localparam int AW          = 2 * LW;
    localparam int DW          = AW + 1;
    localparam int PW          = 2 * DW;
    localparam int FRAC        = 16;
    localparam int OVL_BITS    = FRAC + 1;
    localparam int NREG        = 5;
    localparam int REGION_BITS = 3;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [REGION_BITS-1:0] REG_LEFT_TOP  = 3'd0;
    localparam logic [REGION_BITS-1:0] REG_CENTRE    = 3'd4;

    localparam logic [OVL_BITS-1:0] OVL_ONE = OVL_BITS'(1) << FRAC;

    typedef struct packed {
        logic [AW-1:0] n;
        logic [DW-1:0] d;
    } cand_t;

    typedef struct packed {
        cand_t [NREG-1:0]       cand;
        cand_t                  best;
        logic [REGION_BITS-1:0] code;
    } sel_t;

endpackage

`default_nettype wire

### sv/brc_geom.sv
// brc_geom: clipped extents, areas and iou fractions of the five regions
`timescale 1ns / 1ps
`default_nettype none

module brc_geom (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             item_valid,
    input  wire logic [brc_pkg::COORD_BITS-1:0]   box_left,
    input  wire logic [brc_pkg::COORD_BITS-1:0]   box_top,
    input  wire logic [brc_pkg::COORD_BITS-1:0]   box_right,
    input  wire logic [brc_pkg::COORD_BITS-1:0]   box_bottom,
    input  wire logic [brc_pkg::CFG_BITS-1:0]     image_width,
    input  wire logic [brc_pkg::CFG_BITS-1:0]     image_height,
    output logic                                  sel_valid,
    output brc_pkg::sel_t                         sel_item
);

    localparam int QW   = brc_pkg::QW;
    localparam int LW   = brc_pkg::LW;
    localparam int AW   = brc_pkg::AW;
    localparam int DW   = brc_pkg::DW;
    localparam int NREG = brc_pkg::NREG;

    logic                        v1_reg, v2_reg, v3_reg;
    logic [NREG-1:0]             ok1_reg, ok2_reg;
    logic [NREG-1:0][LW-1:0]     lx1_reg, ly1_reg, rw1_reg, rh1_reg;
    logic [LW-1:0]               ax1_reg, ay1_reg;
    logic [NREG-1:0][AW-1:0]     in2_reg, ab2_reg;
    logic [AW-1:0]               aa2_reg;
    brc_pkg::sel_t               s3_reg;

    logic [NREG-1:0]             ok1_next;
    logic [NREG-1:0][LW-1:0]     lx1_next, ly1_next, rw1_next, rh1_next;
    logic [LW-1:0]               ax1_next, ay1_next;
    brc_pkg::sel_t               s3_next;

    logic [QW-1:0] bl, bt, br, bb;
    logic [QW-1:0] w1, w2, w3, w4, h1, h2, h3, h4;
    logic [NREG-1:0][QW-1:0] xl, xr, yt, yb, x1, x2, y1, y2;
    logic [NREG-1:0][LW-1:0] ex, ey;
    logic rev;

    always_comb
    begin
        bl = QW'({box_left, 2'b00});
        bt = QW'({box_top, 2'b00});
        br = QW'({box_right, 2'b00});
        bb = QW'({box_bottom, 2'b00});
        w1 = QW'(image_width);
        w2 = QW'({image_width, 1'b0});
        w4 = QW'({image_width, 2'b00});
        w3 = w1 + w2;
        h1 = QW'(image_height);
        h2 = QW'({image_height, 1'b0});
        h4 = QW'({image_height, 2'b00});
        h3 = h1 + h2;
        rev = (box_right < box_left) || (box_bottom < box_top);
        // left top, right top, left bottom, right bottom, centre
        xl = {w1, w2, QW'(0), w2, QW'(0)};
        xr = {w3, w4, w2, w4, w2};
        yt = {h1, h2, h2, QW'(0), QW'(0)};
        yb = {h3, h4, h4, h2, h2};
        ax1_next = LW'(br) - LW'(bl) + LW'(4);
        ay1_next = LW'(bb) - LW'(bt) + LW'(4);
        for (int k = 0; k < NREG; k++)
        begin
            x1[k] = (bl > xl[k]) ? bl : xl[k];
            y1[k] = (bt > yt[k]) ? bt : yt[k];
            x2[k] = (br < xr[k]) ? br : xr[k];
            y2[k] = (bb < yb[k]) ? bb : yb[k];
            ex[k] = LW'(x2[k]) - LW'(x1[k]);
            ey[k] = LW'(y2[k]) - LW'(y1[k]);
            ok1_next[k] = !ex[k][LW-1] && !ey[k][LW-1] && !rev;
            lx1_next[k] = ex[k] + LW'(4);
            ly1_next[k] = ey[k] + LW'(4);
            rw1_next[k] = LW'(xr[k]) - LW'(xl[k]) + LW'(4);
            rh1_next[k] = LW'(yb[k]) - LW'(yt[k]) + LW'(4);
        end
    end

    always_comb
    begin
        s3_next = '0;
        for (int k = 0; k < NREG; k++)
        begin
            s3_next.cand[k].n = ok2_reg[k] ? in2_reg[k] : '0;
            s3_next.cand[k].d = DW'(aa2_reg) + DW'(ab2_reg[k]) - DW'(in2_reg[k]);
        end
        s3_next.best.n = '0;
        s3_next.best.d = DW'(1);
        s3_next.code   = brc_pkg::REG_LEFT_TOP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= item_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok1_reg <= ok1_next;
            lx1_reg <= lx1_next;
            ly1_reg <= ly1_next;
            rw1_reg <= rw1_next;
            rh1_reg <= rh1_next;
            ax1_reg <= ax1_next;
            ay1_reg <= ay1_next;
            ok2_reg <= ok1_reg;
            aa2_reg <= ax1_reg * ay1_reg;
            for (int k = 0; k < NREG; k++)
            begin
                in2_reg[k] <= lx1_reg[k] * ly1_reg[k];
                ab2_reg[k] <= rw1_reg[k] * rh1_reg[k];
            end
            s3_reg <= s3_next;
        end
    end

    assign sel_valid = v3_reg;
    assign sel_item  = s3_reg;

endmodule

`default_nettype wire

### sv/brc_cmp.sv
// brc_cmp: one exact fraction compare against the best region so far
`timescale 1ns / 1ps
`default_nettype none

module brc_cmp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic [brc_pkg::REGION_BITS-1:0]    idx,
    input  wire logic                               sel_in_valid,
    input  wire brc_pkg::sel_t                      sel_in,
    output logic                                    sel_out_valid,
    output brc_pkg::sel_t                           sel_out
);

    localparam int DW = brc_pkg::DW;
    localparam int PW = brc_pkg::PW;

    logic              va_reg, vb_reg;
    logic [PW-1:0]     pa_reg, pb_reg;
    brc_pkg::sel_t     sa_reg, sb_reg;
    brc_pkg::sel_t     sb_next;
    brc_pkg::cand_t    cand;

    assign cand = sel_in.cand[idx];

    always_comb
    begin
        sb_next = sa_reg;
        if (pa_reg > pb_reg)
        begin
            sb_next.best = sa_reg.cand[idx];
            sb_next.code = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= sel_in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= DW'(cand.n) * sel_in.best.d;
            pb_reg <= DW'(sel_in.best.n) * cand.d;
            sa_reg <= sel_in;
            sb_reg <= sb_next;
        end
    end

    assign sel_out_valid = vb_reg;
    assign sel_out       = sb_reg;

endmodule

`default_nettype wire

### sv/brc_div.sv
// brc_div: pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module brc_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               div_valid,
    input  wire logic [brc_pkg::AW-1:0]             num,
    input  wire logic [brc_pkg::DW-1:0]             den,
    input  wire logic [brc_pkg::REGION_BITS-1:0]    code,
    output logic                                    q_valid,
    output logic [brc_pkg::REGION_BITS-1:0]         q_code,
    output logic [brc_pkg::OVL_BITS-1:0]            quot
);

    localparam int DW   = brc_pkg::DW;
    localparam int FRAC = brc_pkg::FRAC;
    localparam int QB   = brc_pkg::OVL_BITS;
    localparam int RB   = brc_pkg::REGION_BITS;

    logic [FRAC:0]        v_reg;
    logic [DW-1:0]        r_reg [FRAC+1];
    logic [DW-1:0]        d_reg [FRAC+1];
    logic [QB-1:0]        q_reg [FRAC+1];
    logic [RB-1:0]        c_reg [FRAC+1];
    logic [DW-1:0]        r_next [FRAC+1];
    logic [QB-1:0]        q_next [FRAC+1];
    logic [DW:0]          t;
    logic                 b;

    always_comb
    begin
        t = '0;
        b = 1'b0;
        // iou never exceeds one, so the remainder starts below the divisor after one step
        b = DW'(num) >= den;
        r_next[0] = DW'(num) - (b ? den : '0);
        q_next[0] = QB'(b);
        for (int i = 1; i <= FRAC; i++)
        begin
            t = {r_reg[i-1], 1'b0};
            b = t >= {1'b0, d_reg[i-1]};
            r_next[i] = DW'(t - (b ? {1'b0, d_reg[i-1]} : '0));
            q_next[i] = {q_reg[i-1][QB-2:0], b};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[FRAC-1:0], div_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= den;
            c_reg[0] <= code;
            for (int i = 0; i <= FRAC; i++)
            begin
                r_reg[i] <= r_next[i];
                q_reg[i] <= q_next[i];
            end
            for (int i = 1; i <= FRAC; i++)
            begin
                d_reg[i] <= d_reg[i-1];
                c_reg[i] <= c_reg[i-1];
            end
        end
    end

    assign q_valid = v_reg[FRAC];
    assign q_code  = c_reg[FRAC];
    assign quot    = q_reg[FRAC];

endmodule

`default_nettype wire

### sv/box_region_classifier_iou.sv
// box_region_classifier_iou: top level, config registers and pipeline chain
`timescale 1ns / 1ps
`default_nettype none

// Fully pipelined: takes one box per clock unless a stalled result freezes the whole
// pipe, and returns the best-overlapping image region (quadrants or centre) with its
// intersection over union as a 1.16 fraction, through 3 geometry stages, two stages for
// each of the five exact fraction compares and 17 divider stages, one quotient bit each.
// The user must write image size only while the block is idle; nothing here enforces it.
module box_region_classifier_iou (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               box_valid,
    output logic                                    box_stall,
    input  wire logic [brc_pkg::COORD_BITS-1:0]     box_left,
    input  wire logic [brc_pkg::COORD_BITS-1:0]     box_top,
    input  wire logic [brc_pkg::COORD_BITS-1:0]     box_right,
    input  wire logic [brc_pkg::COORD_BITS-1:0]     box_bottom,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic [brc_pkg::REGION_BITS-1:0]         region,
    output logic [brc_pkg::OVL_BITS-1:0]            best_overlap,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic                               cfg_index,
    input  wire logic [brc_pkg::CFG_BITS-1:0]       cfg_data
);

    localparam int NREG = brc_pkg::NREG;

    logic [brc_pkg::CFG_BITS-1:0] width_reg, height_reg;
    logic                         en;
    logic                         s_valid [NREG+1];
    brc_pkg::sel_t                s_item  [NREG+1];

    assign cfg_ready = 1'b1;
    assign en        = !(result_valid && result_stall);
    assign box_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= brc_pkg::WIDTH_RESET;
            height_reg <= brc_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                brc_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                brc_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    brc_geom u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .item_valid   (box_valid),
        .box_left     (box_left),
        .box_top      (box_top),
        .box_right    (box_right),
        .box_bottom   (box_bottom),
        .image_width  (width_reg),
        .image_height (height_reg),
        .sel_valid    (s_valid[0]),
        .sel_item     (s_item[0])
    );

    for (genvar k = 0; k < NREG; k++)
    begin : g_cmp
        brc_cmp u_cmp (
            .clk           (clk),
            .rst_n         (rst_n),
            .en            (en),
            .idx           (brc_pkg::REGION_BITS'(k)),
            .sel_in_valid  (s_valid[k]),
            .sel_in        (s_item[k]),
            .sel_out_valid (s_valid[k+1]),
            .sel_out       (s_item[k+1])
        );
    end

    brc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .div_valid (s_valid[NREG]),
        .num       (s_item[NREG].best.n),
        .den       (s_item[NREG].best.d),
        .code      (s_item[NREG].code),
        .q_valid   (result_valid),
        .q_code    (region),
        .quot      (best_overlap)
    );

`ifndef ASSERT_OFF
    a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> region <= brc_pkg::REG_CENTRE)
        else $error("region code out of range");

    a_overlap_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> best_overlap <= brc_pkg::OVL_ONE)
        else $error("overlap above one");

    a_best_fraction: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid[NREG] |-> s_item[NREG].best.n <= s_item[NREG].best.d)
        else $error("chosen intersection exceeds union");
`endif

endmodule

`default_nettype wire

### bench/tb_box_region_classifier_iou.sv
// tb_box_region_classifier_iou: self-checking bench for the box region classifier
`timescale 1ns / 1ps

module tb_box_region_classifier_iou;

    typedef struct {
        logic [brc_pkg::COORD_BITS-1:0]  l, t, r, b;
        bit                              typed;
        logic [brc_pkg::REGION_BITS-1:0] rg;
        logic [brc_pkg::OVL_BITS-1:0]    ov;
    } box_row_t;

    typedef struct {
        logic [brc_pkg::REGION_BITS-1:0] rg;
        logic [brc_pkg::OVL_BITS-1:0]    ov;
    } region_score_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic box_valid = 1'b0;
    logic box_stall;
    logic [brc_pkg::COORD_BITS-1:0] box_left = '0, box_top = '0;
    logic [brc_pkg::COORD_BITS-1:0] box_right = '0, box_bottom = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [brc_pkg::REGION_BITS-1:0] region;
    logic [brc_pkg::OVL_BITS-1:0] best_overlap;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = brc_pkg::CFG_WIDTH;
    logic [brc_pkg::CFG_BITS-1:0] cfg_data = '0;

    region_score_t expected_scores[$];
    logic [brc_pkg::CFG_BITS-1:0] img_w = brc_pkg::WIDTH_RESET;
    logic [brc_pkg::CFG_BITS-1:0] img_h = brc_pkg::HEIGHT_RESET;
    int mismatches = 0;
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;
    bit long_hold = 1'b0;

    box_region_classifier_iou u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .box_valid    (box_valid),
        .box_stall    (box_stall),
        .box_left     (box_left),
        .box_top      (box_top),
        .box_right    (box_right),
        .box_bottom   (box_bottom),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .region       (region),
        .best_overlap (best_overlap),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic region_score_t best_region_iou(
        input logic [brc_pkg::COORD_BITS-1:0] l, t, r, b);
        region_score_t res;
        longint bl, bt, br, bb, w, h, x1, y1, x2, y2;
        longint rc[5][4];
        longint unsigned area_a, inter, area_b, den, bn, bd;
        logic [127:0] lhs, rhs;
        int best;
        bl = 4 * longint'(l);
        bt = 4 * longint'(t);
        br = 4 * longint'(r);
        bb = 4 * longint'(b);
        w = longint'(img_w);
        h = longint'(img_h);
        rc[0] = '{0, 0, 2 * w, 2 * h};
        rc[1] = '{2 * w, 0, 4 * w, 2 * h};
        rc[2] = '{0, 2 * h, 2 * w, 4 * h};
        rc[3] = '{2 * w, 2 * h, 4 * w, 4 * h};
        rc[4] = '{w, h, 3 * w, 3 * h};
        bn = 0;
        bd = 1;
        best = 0;
        res.rg = '0;
        res.ov = '0;
        if (br < bl || bb < bt)
            return res;
        area_a = longint'(br - bl + 4) * longint'(bb - bt + 4);
        for (int k = 0; k < 5; k++)
        begin
            x1 = (bl > rc[k][0]) ? bl : rc[k][0];
            y1 = (bt > rc[k][1]) ? bt : rc[k][1];
            x2 = (br < rc[k][2]) ? br : rc[k][2];
            y2 = (bb < rc[k][3]) ? bb : rc[k][3];
            if (x2 < x1 || y2 < y1)
                continue;
            inter = (x2 - x1 + 4) * (y2 - y1 + 4);
            area_b = (rc[k][2] - rc[k][0] + 4) * (rc[k][3] - rc[k][1] + 4);
            den = area_a + area_b - inter;
            lhs = 128'(inter) * 128'(bd);
            rhs = 128'(bn) * 128'(den);
            if (lhs > rhs)
            begin
                bn = inter;
                bd = den;
                best = k;
            end
        end
        res.rg = brc_pkg::REGION_BITS'(best);
        res.ov = brc_pkg::OVL_BITS'((bn << brc_pkg::FRAC) / bd);
        return res;
    endfunction

    task automatic send_box(input box_row_t row);
        region_score_t e;
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            box_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        box_valid  <= 1'b1;
        box_left   <= row.l;
        box_top    <= row.t;
        box_right  <= row.r;
        box_bottom <= row.b;
        do
            @(posedge clk);
        while (box_stall);
        e = best_region_iou(row.l, row.t, row.r, row.b);
        if (row.typed)
        begin
            e.rg = row.rg;
            e.ov = row.ov;
        end
        expected_scores = {expected_scores, e};
    endtask

    task automatic write_image_size(input logic [brc_pkg::CFG_BITS-1:0] w,
                                    input logic [brc_pkg::CFG_BITS-1:0] h);
        box_valid <= 1'b0;
        wait (expected_scores.size() == 0);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= brc_pkg::CFG_WIDTH;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        img_w = w;
        cfg_index <= brc_pkg::CFG_HEIGHT;
        cfg_data  <= h;
        do
            @(posedge clk);
        while (!cfg_ready);
        img_h = h;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic box_row_t random_box();
        box_row_t row;
        int span, kind, cx, cy;
        row.typed = 1'b0;
        row.rg = '0;
        row.ov = '0;
        kind = $urandom_range(0, 9);
        span = (img_w > img_h ? img_w : img_h) + 4;
        if (span > 4095)
            span = 4095;
        if (kind < 6)
        begin
            row.l = brc_pkg::COORD_BITS'($urandom_range(0, span));
            row.t = brc_pkg::COORD_BITS'($urandom_range(0, span));
            row.r = brc_pkg::COORD_BITS'(row.l + $urandom_range(0, span - row.l));
            row.b = brc_pkg::COORD_BITS'(row.t + $urandom_range(0, span - row.t));
        end
        else if (kind < 8)
        begin
            row.l = brc_pkg::COORD_BITS'($urandom);
            row.t = brc_pkg::COORD_BITS'($urandom);
            row.r = brc_pkg::COORD_BITS'($urandom);
            row.b = brc_pkg::COORD_BITS'($urandom);
        end
        else
        begin
            // boxes around the quadrant and centre corners
            cx = (img_w / 4) * $urandom_range(1, 3);
            cy = (img_h / 4) * $urandom_range(1, 3);
            row.l = brc_pkg::COORD_BITS'(cx > 2 ? cx - $urandom_range(0, 2) : 0);
            row.t = brc_pkg::COORD_BITS'(cy > 2 ? cy - $urandom_range(0, 2) : 0);
            row.r = brc_pkg::COORD_BITS'(cx + $urandom_range(0, img_w / 2 + 1));
            row.b = brc_pkg::COORD_BITS'(cy + $urandom_range(0, img_h / 2 + 1));
        end
        return row;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        region_score_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_scores.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected item: region %0d overlap %0d", region, best_overlap);
                mismatches++;
            end
            else
            begin
                e = expected_scores.pop_front();
                if (region !== e.rg || best_overlap !== e.ov)
                begin
                    if (mismatches < 10)
                        $display("mismatch: region %0d/%0d overlap %0d/%0d (exp/got)",
                                 e.rg, region, e.ov, best_overlap);
                    mismatches++;
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        bit v;
        int dur;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                v = 1'b1;
                dur = 200;
                long_hold = 1'b0;
            end
            else if (!receiver_idles)
            begin
                v = 1'b0;
                dur = 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                v = 1'b1;
                dur = $urandom_range(1, 3);
            end
            else
            begin
                v = 1'b0;
                dur = $urandom_range(1, 4);
            end
            result_stall <= v;
            repeat (dur) @(posedge clk);
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb_box_region_classifier_iou: done, errors");
        $finish;
    end

    initial
    begin
        box_row_t dir_rows[$];
        logic [brc_pkg::CFG_BITS-1:0] ws[7], hs[7];
        dir_rows = '{
            '{12'd10, 12'd0, 12'd5, 12'd0, 1'b1, brc_pkg::REG_LEFT_TOP, '0},
            '{12'd0, 12'd20, 12'd5, 12'd10, 1'b1, brc_pkg::REG_LEFT_TOP, '0},
            '{12'd0, 12'd0, 12'd320, 12'd240, 1'b1, brc_pkg::REG_LEFT_TOP, brc_pkg::OVL_ONE},
            '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, brc_pkg::REG_LEFT_TOP, '0},
            '{12'd4095, 12'd0, 12'd0, 12'd4095, 1'b1, brc_pkg::REG_LEFT_TOP, '0},
            '{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0, '0},
            '{12'd0, 12'd0, 12'd4095, 12'd4095, 1'b0, '0, '0},
            '{12'd320, 12'd0, 12'd640, 12'd240, 1'b0, '0, '0},
            '{12'd0, 12'd240, 12'd320, 12'd480, 1'b0, '0, '0},
            '{12'd320, 12'd240, 12'd640, 12'd480, 1'b0, '0, '0},
            '{12'd160, 12'd120, 12'd480, 12'd360, 1'b0, '0, '0},
            '{12'd319, 12'd239, 12'd321, 12'd241, 1'b0, '0, '0},
            '{12'd320, 12'd240, 12'd320, 12'd240, 1'b0, '0, '0},
            '{12'd641, 12'd0, 12'd700, 12'd100, 1'b0, '0, '0},
            '{12'd0, 12'd481, 12'd100, 12'd600, 1'b0, '0, '0},
            '{12'd100, 12'd100, 12'd100, 12'd4095, 1'b0, '0, '0},
            '{12'd2730, 12'd1365, 12'd4095, 12'd2730, 1'b0, '0, '0},
            '{12'd1365, 12'd2730, 12'd2730, 12'd1365, 1'b0, '0, '0},
            '{12'd0, 12'd4095, 12'd4095, 12'd4095, 1'b0, '0, '0},
            '{12'd4095, 12'd0, 12'd4095, 12'd4095, 1'b0, '0, '0}
        };
        ws = '{640, 1, 4096, 0, 8191, 100, 1};
        hs = '{480, 1, 4096, 0, 8191, 3000, 4096};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_box(dir_rows[i]);
        for (int p = 0; p < 7; p++)
        begin
            write_image_size(ws[p] + (p == 6 ? brc_pkg::CFG_BITS'($urandom_range(0, 2000)) : '0),
                             hs[p]);
            if (p == 6)
            begin
                sender_idles = 1'b0;
                receiver_idles = 1'b0;
            end
            for (int i = 0; i < 240; i++)
            begin
                if (p == 2 && i == 20)
                    long_hold = 1'b1;
                send_box(random_box());
            end
        end
        box_valid <= 1'b0;
        wait (expected_scores.size() == 0);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("tb_box_region_classifier_iou: done, clean");
        else
            $display("tb_box_region_classifier_iou: done, errors");
        $finish;
    end

endmodule

### sim.f
sv/brc_pkg.sv
sv/brc_geom.sv
sv/brc_cmp.sv
sv/brc_div.sv
sv/box_region_classifier_iou.sv
bench/tb_box_region_classifier_iou.sv
